[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

[rtl/tmri_pkg.sv]
// Package with op codes, status codes and constants of the tape interpreter.
package tmri_pkg;
    typedef enum logic [3:0] {
        OP_LEFT   = 4'd0,
        OP_RIGHT  = 4'd1,
        OP_PLUS   = 4'd2,
        OP_MINUS  = 4'd3,
        OP_INPUT  = 4'd4,
        OP_OUTPUT = 4'd5,
        OP_REPEAT = 4'd6,
        OP_OPEN   = 4'd7,
        OP_CLOSE  = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SYNTAX    = 3'd1,
        ST_TAPE_OVF  = 3'd2,
        ST_STACK_OVF = 3'd3,
        ST_HALTED    = 3'd4
    } status_t;

    localparam logic [6:0]  LEVEL_MAX = 7'd127;
    localparam logic [15:0] RUN_MAX   = 16'hFFFF;
endpackage

[rtl/tape_machine_repeat_interpreter.sv]
// Top level of the tape interpreter: tape memory, loop stack memory and control.
//
//  channel | ports                                   | direction
//  input   | s_valid s_ready s_req_type s_prog_pos   | in
//          | s_in_byte                               |
//  result  | m_valid m_ready m_out_* m_in_used m_jump | out
//          | _* m_skipping m_status                  |
//
// Each item first reads the tape cell and stack top from their synchronous
// memories, then is computed and written back; no item is accepted meanwhile.
// After reset a clearing pass zeroes the tape, one cell a cycle; no item is
// accepted during the pass.
// While a result waits in the output register, a new item is accepted only in
// the cycle in which that result transfers.
module tape_machine_repeat_interpreter #(
    parameter int TAPE_CELLS  = 4096,
    parameter int STACK_DEPTH = 64,
    parameter int POS_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_req_type,
    input  logic [15:0] s_prog_pos,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_valid,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_out_count,
    output logic [15:0] m_in_used,
    output logic        m_jump_valid,
    output logic [15:0] m_jump_pos,
    output logic        m_skipping,
    output logic [2:0]  m_status
);
    localparam int HB = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
    localparam int SB = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CB = $clog2(STACK_DEPTH + 1);
    localparam int WB = (HB >= 16) ? HB + 1 : 17;
    localparam logic [CB-1:0] DEPTH_C = CB'(STACK_DEPTH);

    logic [7:0]          tape_mem [TAPE_CELLS];
    logic [POS_BITS-1:0] stack_mem [STACK_DEPTH];

    logic [HB-1:0]  head_reg, head_next;
    logic [CB-1:0]  cnt_reg, cnt_next;
    logic           skip_reg, skip_next;
    logic [6:0]     lvl_reg, lvl_next;
    logic [3:0]     last_reg, last_next;
    logic [15:0]    run_reg, run_next;
    logic           halt_reg, halt_next;
    logic           clr_reg;
    logic [HB-1:0]  clr_addr_reg;
    logic           busy_reg;
    logic [3:0]     op_reg;
    logic [15:0]    pos_reg;
    logic [7:0]     inb_reg;
    logic [7:0]     cell_rd_reg;
    logic [POS_BITS-1:0] top_rd_reg;

    logic        t_we;
    logic [HB-1:0] t_wa;
    logic [7:0]  t_wd;
    logic        s_we;
    logic [SB-1:0] s_wa;
    logic [SB-1:0] top_addr;
    logic        accept, finish;

    logic        o_out_valid, o_jump_valid;
    logic [7:0]  o_out_byte;
    logic [15:0] o_out_count, o_in_used, o_jump_pos;
    logic [2:0]  o_status;

    assign s_ready = !clr_reg && !busy_reg && (!m_valid || m_ready);
    assign accept  = s_valid && s_ready;
    assign finish  = busy_reg;
    assign top_addr = (cnt_reg == '0) ? '0 : SB'(cnt_reg - CB'(1));

    // memory read ports: cell under head and top of stack
    always_ff @(posedge aclk) begin
        cell_rd_reg <= tape_mem[head_reg];
        top_rd_reg  <= stack_mem[top_addr];
        if (t_we) begin
            tape_mem[t_wa] <= t_wd;
        end
        if (s_we) begin
            stack_mem[s_wa] <= POS_BITS'(pos_reg);
        end
    end

    always_comb begin
        logic [7:0]  cur_cell;
        logic [15:0] r;
        logic [3:0]  eop;
        logic [2:0]  st;
        logic        apply;
        logic [WB-1:0] hx;
        logic [WB-1:0] rx;
        logic [16:0] dbl;
        cur_cell = cell_rd_reg;
        head_next = head_reg; cnt_next = cnt_reg; skip_next = skip_reg;
        lvl_next = lvl_reg; last_next = last_reg; run_next = run_reg;
        halt_next = halt_reg;
        t_we = 1'b0; t_wa = head_reg; t_wd = cur_cell;
        s_we = 1'b0; s_wa = SB'(cnt_reg);
        o_out_valid = 1'b0; o_out_byte = '0; o_out_count = '0; o_in_used = '0;
        o_jump_valid = 1'b0; o_jump_pos = '0;
        st = tmri_pkg::ST_OK;
        apply = 1'b0; eop = op_reg; r = 16'd1;
        hx = WB'(head_reg);
        rx = '0;
        dbl = {run_reg, 1'b0};
        if (clr_reg) begin
            t_we = 1'b1; t_wa = clr_addr_reg; t_wd = '0;
        end else if (finish) begin
            if (halt_reg) begin
                st = tmri_pkg::ST_HALTED;
            end else if (skip_reg) begin
                if (op_reg == tmri_pkg::OP_OPEN) begin
                    if (lvl_reg >= tmri_pkg::LEVEL_MAX) st = tmri_pkg::ST_STACK_OVF;
                    else lvl_next = lvl_reg + 7'd1;
                end else if (op_reg == tmri_pkg::OP_CLOSE) begin
                    if (lvl_reg != '0) begin
                        lvl_next = lvl_reg - 7'd1;
                    end else begin
                        if (cnt_reg != '0) cnt_next = cnt_reg - CB'(1);
                        skip_next = 1'b0;
                    end
                end
            end else if (op_reg <= 4'd5) begin
                apply = 1'b1;
            end else if (op_reg == tmri_pkg::OP_REPEAT) begin
                if (run_reg == '0) begin
                    st = tmri_pkg::ST_SYNTAX;
                end else if (last_reg <= 4'd5) begin
                    apply = 1'b1; eop = last_reg; r = run_reg;
                end else begin
                    run_next = dbl[16] ? tmri_pkg::RUN_MAX : dbl[15:0];
                end
            end else if (op_reg == tmri_pkg::OP_OPEN) begin
                if (cnt_reg >= DEPTH_C) begin
                    st = tmri_pkg::ST_STACK_OVF;
                end else begin
                    s_we = 1'b1;
                    cnt_next = cnt_reg + CB'(1);
                    run_next = '0;
                    if (cur_cell == '0) begin skip_next = 1'b1; lvl_next = '0; end
                end
            end else if (op_reg == tmri_pkg::OP_CLOSE) begin
                if (cnt_reg == '0) begin
                    st = tmri_pkg::ST_SYNTAX;
                end else begin
                    o_jump_valid = 1'b1;
                    o_jump_pos = 16'(top_rd_reg);
                    run_next = '0;
                    if (cur_cell == '0) begin skip_next = 1'b1; lvl_next = '0; end
                end
            end
            if (apply) begin
                rx = WB'(r);
                case (eop)
                    tmri_pkg::OP_LEFT: begin
                        if (hx < rx) st = tmri_pkg::ST_TAPE_OVF;
                        else head_next = HB'(hx - rx);
                    end
                    tmri_pkg::OP_RIGHT: begin
                        if (hx + rx > WB'(TAPE_CELLS - 1)) st = tmri_pkg::ST_TAPE_OVF;
                        else head_next = HB'(hx + rx);
                    end
                    tmri_pkg::OP_PLUS: begin t_we = 1'b1; t_wd = cur_cell + r[7:0]; end
                    tmri_pkg::OP_MINUS: begin t_we = 1'b1; t_wd = cur_cell - r[7:0]; end
                    tmri_pkg::OP_INPUT: begin
                        t_we = 1'b1; t_wd = inb_reg; o_in_used = r;
                    end
                    tmri_pkg::OP_OUTPUT: begin
                        o_out_valid = 1'b1; o_out_byte = cur_cell; o_out_count = r;
                    end
                    default: ;
                endcase
                if (st == tmri_pkg::ST_OK) begin
                    if (op_reg == tmri_pkg::OP_REPEAT) begin
                        run_next = dbl[16] ? tmri_pkg::RUN_MAX : dbl[15:0];
                    end else if (last_reg == op_reg) begin
                        if (run_reg != tmri_pkg::RUN_MAX) run_next = run_reg + 16'd1;
                    end else begin
                        last_next = op_reg; run_next = 16'd1;
                    end
                end
            end
            if (st != tmri_pkg::ST_OK && st != tmri_pkg::ST_HALTED) begin
                halt_next = 1'b1;
                head_next = head_reg; cnt_next = cnt_reg; skip_next = skip_reg;
                lvl_next = lvl_reg; last_next = last_reg; run_next = run_reg;
                t_we = 1'b0; s_we = 1'b0;
                o_out_valid = 1'b0; o_out_byte = '0; o_out_count = '0; o_in_used = '0;
                o_jump_valid = 1'b0; o_jump_pos = '0;
            end
        end
        o_status = st;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= HB'(TAPE_CELLS / 2);
            cnt_reg <= '0; skip_reg <= 1'b0; lvl_reg <= '0;
            last_reg <= tmri_pkg::OP_CLOSE; run_reg <= '0; halt_reg <= 1'b0;
            clr_reg <= 1'b1; clr_addr_reg <= '0;
            busy_reg <= 1'b0; m_valid <= 1'b0;
        end else begin
            head_reg <= head_next; cnt_reg <= cnt_next; skip_reg <= skip_next;
            lvl_reg <= lvl_next; last_reg <= last_next; run_reg <= run_next;
            halt_reg <= halt_next;
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + HB'(1);
                if (clr_addr_reg == HB'(TAPE_CELLS - 1)) clr_reg <= 1'b0;
            end
            busy_reg <= accept;
            if (finish) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= s_req_type;
            pos_reg <= 16'(POS_BITS'(s_prog_pos));
            inb_reg <= s_in_byte;
        end
        if (finish) begin
            m_out_valid <= o_out_valid; m_out_byte <= o_out_byte;
            m_out_count <= o_out_count; m_in_used <= o_in_used;
            m_jump_valid <= o_jump_valid; m_jump_pos <= o_jump_pos;
            m_skipping <= skip_next; m_status <= o_status;
        end
    end
endmodule

[rtl/tmri_checker.sv]
// Port-level checker for the tape interpreter, bound to the top level.
`include "assert_macros.svh"
module tmri_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_out_valid,
    input logic [15:0] m_out_count,
    input logic        m_jump_valid,
    input logic [15:0] m_jump_pos,
    input logic [2:0]  m_status
);
    `CHK_NEXT(a_result_follows, aclk, aresetn, s_valid && s_ready, ##1 m_valid)
    `CHK_IMPLY(a_status_range, aclk, aresetn, m_valid, m_status <= tmri_pkg::ST_HALTED)
    `CHK_IMPLY(a_err_quiet, aclk, aresetn, m_valid && m_status != tmri_pkg::ST_OK, !m_out_valid && !m_jump_valid)
    `CHK_IMPLY(a_out_count, aclk, aresetn, m_valid && m_out_valid, m_out_count != 16'd0)
    `CHK_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_jump_pos))
endmodule

bind tape_machine_repeat_interpreter tmri_checker u_tmri_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_out_valid(m_out_valid),
    .m_out_count(m_out_count), .m_jump_valid(m_jump_valid),
    .m_jump_pos(m_jump_pos), .m_status(m_status)
);

[verif/testbench.sv]
// Self-checking testbench for the tape interpreter with its repeat instruction.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPE_CELLS  = 4096;
    localparam int STACK_DEPTH = 64;
    localparam int LAST_CELL   = TAPE_CELLS - 1;
    localparam int WATCHDOG    = 20000;
    localparam int DRAIN       = 20;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_TAIL  = 300;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [15:0] out_count;
        logic [15:0] in_used;
        logic        jump_valid;
        logic [15:0] jump_pos;
        logic        skipping;
        tmri_pkg::status_t status;
    } step_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_req_type;
    logic [15:0] s_prog_pos;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_out_valid;
    logic [7:0]  m_out_byte;
    logic [15:0] m_out_count;
    logic [15:0] m_in_used;
    logic        m_jump_valid;
    logic [15:0] m_jump_pos;
    logic        m_skipping;
    logic [2:0]  m_status;

    tape_machine_repeat_interpreter uut (.*);

    // Shadow machine state
    logic [7:0]  tape_mem [TAPE_CELLS];
    logic [15:0] bracket_stack [STACK_DEPTH];
    int          head_pos;
    int          bracket_depth;
    bit          skip_mode;
    int          nest_level;
    logic [3:0]  prev_op;
    int          run_len;
    bit          halted;

    step_result_t pending_results[$];
    int          fail_count;
    bit          send_gaps;
    bit          recv_stalls;
    int          stall_left;
    int          idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int sat_run(int v);
        return (v > int'(tmri_pkg::RUN_MAX)) ? int'(tmri_pkg::RUN_MAX) : v;
    endfunction

    // Apply one basic op r times; returns the status it raises.
    function automatic tmri_pkg::status_t run_op(logic [3:0] op, int r, logic [7:0] inb,
                                                 inout step_result_t res);
        case (op)
            tmri_pkg::OP_LEFT: begin
                if (r > head_pos) return tmri_pkg::ST_TAPE_OVF;
                head_pos -= r;
            end
            tmri_pkg::OP_RIGHT: begin
                if (head_pos + r > LAST_CELL) return tmri_pkg::ST_TAPE_OVF;
                head_pos += r;
            end
            tmri_pkg::OP_PLUS:  tape_mem[head_pos] = tape_mem[head_pos] + 8'(r);
            tmri_pkg::OP_MINUS: tape_mem[head_pos] = tape_mem[head_pos] - 8'(r);
            tmri_pkg::OP_INPUT: begin
                tape_mem[head_pos] = inb;
                res.in_used = 16'(r);
            end
            tmri_pkg::OP_OUTPUT: begin
                res.out_valid = 1'b1;
                res.out_byte  = tape_mem[head_pos];
                res.out_count = 16'(r);
            end
            default: ;
        endcase
        return tmri_pkg::ST_OK;
    endfunction

    function automatic step_result_t execute_instr(logic [3:0] op, logic [15:0] pos,
                                                   logic [7:0] inb);
        step_result_t res;
        tmri_pkg::status_t st;
        res = '0;
        st = tmri_pkg::ST_OK;
        if (halted) begin
            res.skipping = skip_mode;
            res.status = tmri_pkg::ST_HALTED;
            return res;
        end
        if (skip_mode) begin
            if (op == tmri_pkg::OP_OPEN) begin
                if (nest_level >= int'(tmri_pkg::LEVEL_MAX)) st = tmri_pkg::ST_STACK_OVF;
                else nest_level++;
            end else if (op == tmri_pkg::OP_CLOSE) begin
                if (nest_level > 0) begin
                    nest_level--;
                end else begin
                    if (bracket_depth > 0) bracket_depth--;
                    skip_mode = 1'b0;
                end
            end
        end else if (op <= tmri_pkg::OP_OUTPUT) begin
            st = run_op(op, 1, inb, res);
            if (st == tmri_pkg::ST_OK) begin
                if (prev_op == op) begin
                    run_len = sat_run(run_len + 1);
                end else begin
                    prev_op = op;
                    run_len = 1;
                end
            end
        end else if (op == tmri_pkg::OP_REPEAT) begin
            if (run_len < 1) begin
                st = tmri_pkg::ST_SYNTAX;
            end else if (prev_op <= tmri_pkg::OP_OUTPUT) begin
                st = run_op(prev_op, run_len, inb, res);
                if (st == tmri_pkg::ST_OK) run_len = sat_run(run_len * 2);
            end else begin
                run_len = sat_run(run_len * 2);
            end
        end else if (op == tmri_pkg::OP_OPEN) begin
            if (bracket_depth >= STACK_DEPTH) begin
                st = tmri_pkg::ST_STACK_OVF;
            end else begin
                bracket_stack[bracket_depth] = pos;
                bracket_depth++;
                run_len = 0;
                if (tape_mem[head_pos] == 8'd0) begin
                    skip_mode = 1'b1;
                    nest_level = 0;
                end
            end
        end else if (op == tmri_pkg::OP_CLOSE) begin
            if (bracket_depth == 0) begin
                st = tmri_pkg::ST_SYNTAX;
            end else begin
                res.jump_valid = 1'b1;
                res.jump_pos = bracket_stack[bracket_depth - 1];
                run_len = 0;
                if (tape_mem[head_pos] == 8'd0) begin
                    skip_mode = 1'b1;
                    nest_level = 0;
                end
            end
        end
        if (st != tmri_pkg::ST_OK) begin
            halted = 1'b1;
            res = '0;
        end
        res.skipping = skip_mode;
        res.status = st;
        return res;
    endfunction

    // True when the op would raise an error in the current state.
    function automatic bit would_fault(logic [3:0] op);
        if (skip_mode)
            return (op == tmri_pkg::OP_OPEN) && (nest_level >= int'(tmri_pkg::LEVEL_MAX));
        case (op)
            tmri_pkg::OP_LEFT:   return head_pos == 0;
            tmri_pkg::OP_RIGHT:  return head_pos == LAST_CELL;
            tmri_pkg::OP_REPEAT: return (run_len == 0)
                           || (prev_op == tmri_pkg::OP_LEFT && run_len > head_pos)
                           || (prev_op == tmri_pkg::OP_RIGHT
                               && head_pos + run_len > LAST_CELL);
            tmri_pkg::OP_OPEN:   return bracket_depth >= STACK_DEPTH;
            tmri_pkg::OP_CLOSE:  return bracket_depth == 0;
            default:   return 1'b0;
        endcase
    endfunction

    // Call at a rising edge; returns at the edge of the transfer, or later if a random gap follows.
    task automatic send_instr(logic [3:0] op, logic [15:0] pos, logic [7:0] inb);
        pending_results.push_back(execute_instr(op, pos, inb));
        s_valid    <= 1'b1;
        s_req_type <= op;
        s_prog_pos <= pos;
        s_in_byte  <= inb;
        do @(posedge aclk); while (!s_ready);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_op(logic [3:0] op);
        send_instr(op, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    endtask

    task automatic leave_skip();
        while (skip_mode) send_op(tmri_pkg::OP_CLOSE);
    endtask

    task automatic test_basic_ops();
        send_instr(tmri_pkg::OP_PLUS, 16'h0000, 8'h00);
        send_instr(tmri_pkg::OP_REPEAT, 16'hFFFF, 8'hFF);
        send_instr(tmri_pkg::OP_MINUS, 16'h0001, 8'h00);
        send_instr(tmri_pkg::OP_REPEAT, 16'h8000, 8'h00);
        send_instr(tmri_pkg::OP_RIGHT, 16'h0002, 8'h00);
        send_instr(tmri_pkg::OP_REPEAT, 16'h0003, 8'h00);
        send_instr(tmri_pkg::OP_LEFT, 16'h0004, 8'h00);
        send_instr(tmri_pkg::OP_REPEAT, 16'h0005, 8'h00);
        send_instr(tmri_pkg::OP_INPUT, 16'h0006, 8'hFF);
        send_instr(tmri_pkg::OP_REPEAT, 16'h0007, 8'h00);
        send_instr(tmri_pkg::OP_INPUT, 16'h0008, 8'h80);
        send_instr(tmri_pkg::OP_OUTPUT, 16'h0009, 8'h00);
        send_instr(tmri_pkg::OP_REPEAT, 16'h000A, 8'h00);
        send_instr(tmri_pkg::OP_OPEN, 16'hFFFF, 8'h00);
        send_instr(tmri_pkg::OP_CLOSE, 16'h1234, 8'h00);
        send_instr(4'd9, 16'h5555, 8'hAA);
        send_instr(4'd15, 16'hAAAA, 8'h55);
        send_instr(tmri_pkg::OP_INPUT, 16'h0010, 8'h00);
        send_instr(tmri_pkg::OP_OPEN, 16'h0011, 8'h00);
        send_instr(tmri_pkg::OP_OUTPUT, 16'h0012, 8'h00);
        send_instr(tmri_pkg::OP_CLOSE, 16'h0013, 8'h00);
    endtask

    // Double the run count until it saturates.
    task automatic test_run_saturation();
        leave_skip();
        send_op(tmri_pkg::OP_PLUS);
        repeat (18) send_op(tmri_pkg::OP_REPEAT);
        send_op(tmri_pkg::OP_PLUS);
    endtask

    task automatic test_random_programs();
        logic [3:0] op;
        int pick;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_TAIL) begin
                send_gaps = 1'b0;
                recv_stalls = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12)      op = tmri_pkg::OP_LEFT;
            else if (pick < 24) op = tmri_pkg::OP_RIGHT;
            else if (pick < 39) op = tmri_pkg::OP_PLUS;
            else if (pick < 48) op = tmri_pkg::OP_MINUS;
            else if (pick < 56) op = tmri_pkg::OP_INPUT;
            else if (pick < 66) op = tmri_pkg::OP_OUTPUT;
            else if (pick < 81) op = tmri_pkg::OP_REPEAT;
            else if (pick < 89) op = tmri_pkg::OP_OPEN;
            else if (pick < 97) op = tmri_pkg::OP_CLOSE;
            else                op = 4'($urandom_range(9, 15));
            if (would_fault(op)) op = tmri_pkg::OP_PLUS;
            send_op(op);
        end
    endtask

    task automatic test_pause_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        send_op(tmri_pkg::OP_OUTPUT);
    endtask

    // One error per run, since only reset clears the halt.
    task automatic test_error_halt();
        leave_skip();
        case ($urandom_range(0, 3))
            0: begin
                if (bracket_depth < STACK_DEPTH) send_op(tmri_pkg::OP_OPEN);
                else send_op(tmri_pkg::OP_CLOSE);
                leave_skip();
                send_op(tmri_pkg::OP_REPEAT);
            end
            1: begin
                while (head_pos > 0) begin
                    if (prev_op == tmri_pkg::OP_LEFT && run_len > 0 && run_len <= head_pos)
                        send_op(tmri_pkg::OP_REPEAT);
                    else
                        send_op(tmri_pkg::OP_LEFT);
                end
                send_op(tmri_pkg::OP_LEFT);
            end
            2: begin
                send_instr(tmri_pkg::OP_INPUT, 16'h0000, 8'h01);
                while (bracket_depth < STACK_DEPTH) send_op(tmri_pkg::OP_OPEN);
                send_op(tmri_pkg::OP_OPEN);
            end
            default: begin
                send_instr(tmri_pkg::OP_INPUT, 16'h0000, 8'h00);
                if (bracket_depth < STACK_DEPTH) send_op(tmri_pkg::OP_OPEN);
                else send_op(tmri_pkg::OP_CLOSE);
                repeat (int'(tmri_pkg::LEVEL_MAX) + 1) send_op(tmri_pkg::OP_OPEN);
            end
        endcase
        repeat (6) send_op(4'($urandom_range(0, 15)));
    endtask

    // Result check and ready generation
    always @(posedge aclk) begin
        step_result_t seen;
        step_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_out_valid, m_out_byte, m_out_count, m_in_used, m_jump_valid,
                    m_jump_pos, m_skipping, tmri_pkg::status_t'(m_status)};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch at %0t: expected out %0b/%h/%0d used %0d ",
                                  "jump %0b/%h skip %0b st %0d, got out %0b/%h/%0d ",
                                  "used %0d jump %0b/%h skip %0b st %0d"}, $realtime,
                                 want.out_valid, want.out_byte, want.out_count,
                                 want.in_used, want.jump_valid, want.jump_pos,
                                 want.skipping, want.status, seen.out_valid,
                                 seen.out_byte, seen.out_count, seen.in_used,
                                 seen.jump_valid, seen.jump_pos, seen.skipping,
                                 seen.status);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_req_type <= '0;
        s_prog_pos <= '0;
        s_in_byte  <= '0;
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        foreach (tape_mem[i]) tape_mem[i] = 8'd0;
        foreach (bracket_stack[i]) bracket_stack[i] = 16'd0;
        head_pos = TAPE_CELLS / 2;
        bracket_depth = 0;
        skip_mode = 1'b0;
        nest_level = 0;
        prev_op = tmri_pkg::OP_CLOSE;
        run_len = 0;
        halted = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_run_saturation();
        test_pause_drain();
        test_random_programs();
        test_error_halt();

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/tmri_pkg.sv
rtl/tape_machine_repeat_interpreter.sv
rtl/tmri_checker.sv
verif/testbench.sv
